/* hw/rtl/graph_dfs_bfs_order_unit_macros.svh */
// ----------------------------------------------------------------------------
// graph_dfs_bfs_order_unit_macros
// assertion macros shared by the traversal unit
// ----------------------------------------------------------------------------
`ifndef GRAPH_DFS_BFS_ORDER_UNIT_MACROS_SVH
`define GRAPH_DFS_BFS_ORDER_UNIT_MACROS_SVH

// same-cycle implication
`define GDBO_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GDBO_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/gdbo_pkg.sv */
// ----------------------------------------------------------------------------
// gdbo_pkg
// shared constants, types and helpers of the graph traversal unit
// ----------------------------------------------------------------------------
`default_nettype none

package gdbo_pkg;

  localparam int MAX_V = 32;
  localparam int VID_W = 6;
  localparam int IDX_W = $clog2(MAX_V);
  localparam int CNT_W = IDX_W + 1;

  // datapath commands
  typedef enum logic [2:0] {
    CMD_NONE       = 3'd0,
    CMD_LOAD       = 3'd1,
    CMD_DFS_ROOT   = 3'd2,
    CMD_DFS_STEP   = 3'd3,
    CMD_BFS_ROOT   = 3'd4,
    CMD_BFS_POP    = 3'd5,
    CMD_BFS_EXPAND = 3'd6,
    CMD_CLEAR      = 3'd7
  } cmd_op_t;

  // datapath status back to the controller
  typedef struct packed {
    logic stack_empty;
    logic cand_none;
    logic queue_empty;
  } status_t;

  // index of the lowest set bit, zero when none
  function automatic logic [IDX_W-1:0] lowest_set(input logic [MAX_V-1:0] x);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = MAX_V - 1; i >= 0; i--) begin
      if (x[i]) r = IDX_W'(i);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/graph_dfs_bfs_order_unit.sv */
// ----------------------------------------------------------------------------
// graph_dfs_bfs_order_unit
// loads directed edges into a bit matrix, then emits depth-first and
// breadth-first visit orders from vertex 1
// ----------------------------------------------------------------------------
//
//  channel   | handshake               | payload
//  ----------+-------------------------+-------------------------------------
//  edge in   | start, busy             | from_vertex, to_vertex, last_edge
//  result    | result_strobe           | visited_vertex, traversal_kind,
//            |                         | end_of_run
//  config    | cfg_write               | cfg_data (vertex_count)
//
//  an edge item is taken when start is high and busy is low; busy stays
//  low between ordinary edges; the item with last_edge set starts a root
//  step and the depth-first walk (push then pop of the stack for each
//  reachable vertex), then a root step and the breadth-first walk (pop a
//  vertex, enqueue each newly found neighbor, emit the vertex), then the
//  final clear; one matrix row read and one lowest-bit pick per cycle
//  rst clears matrix, marks, pointers and sets vertex_count to 32
//  results are strobed for one cycle; the receiver cannot stall
//
`default_nettype none

module graph_dfs_bfs_order_unit import gdbo_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  // edge items
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [VID_W-1:0] from_vertex,
  input  wire logic [VID_W-1:0] to_vertex,
  input  wire logic             last_edge,
  // vertex count register
  input  wire logic             cfg_write,
  input  wire logic [VID_W-1:0] cfg_data,
  // visit order results
  output logic                  result_strobe,
  output logic [VID_W-1:0]      visited_vertex,
  output logic                  traversal_kind,
  output logic                  end_of_run
);

  cmd_op_t op;
  status_t status;

  // controller: decides which datapath step runs each cycle
  gdbo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .last_edge (last_edge),
    .status    (status),
    .op        (op),
    .busy      (busy)
  );

  // datapath: matrix, stack, queue, marks and result register
  gdbo_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .op             (op),
    .from_vertex    (from_vertex),
    .to_vertex      (to_vertex),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .status         (status),
    .result_strobe  (result_strobe),
    .visited_vertex (visited_vertex),
    .traversal_kind (traversal_kind),
    .end_of_run     (end_of_run)
  );

endmodule

`default_nettype wire

/* hw/rtl/gdbo_ctrl.sv */
// ----------------------------------------------------------------------------
// gdbo_ctrl
// sequencer for edge loading, depth-first walk, breadth-first walk and clear
// ----------------------------------------------------------------------------
`default_nettype none

module gdbo_ctrl import gdbo_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire logic    last_edge,
  input  wire status_t status,
  output cmd_op_t      op,
  output logic         busy
);

  typedef enum logic [6:0] {
    ST_IDLE       = 7'b0000001,
    ST_DFS_ROOT   = 7'b0000010,
    ST_DFS_STEP   = 7'b0000100,
    ST_BFS_ROOT   = 7'b0001000,
    ST_BFS_POP    = 7'b0010000,
    ST_BFS_EXPAND = 7'b0100000,
    ST_CLEAR      = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    op         = CMD_NONE;
    case (state)
      ST_IDLE: begin
        if (start) begin
          op = CMD_LOAD;
          if (last_edge) state_next = ST_DFS_ROOT;
        end
      end
      ST_DFS_ROOT: begin
        op         = CMD_DFS_ROOT;
        state_next = ST_DFS_STEP;
      end
      ST_DFS_STEP: begin
        if (status.stack_empty) begin
          state_next = ST_BFS_ROOT;
        end else begin
          op = CMD_DFS_STEP;
        end
      end
      ST_BFS_ROOT: begin
        op         = CMD_BFS_ROOT;
        state_next = ST_BFS_POP;
      end
      ST_BFS_POP: begin
        op         = CMD_BFS_POP;
        state_next = ST_BFS_EXPAND;
      end
      ST_BFS_EXPAND: begin
        op = CMD_BFS_EXPAND;
        if (status.cand_none) begin
          state_next = status.queue_empty ? ST_CLEAR : ST_BFS_POP;
        end
      end
      ST_CLEAR: begin
        op         = CMD_CLEAR;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/gdbo_dpath.sv */
// ----------------------------------------------------------------------------
// gdbo_dpath
// adjacency matrix, visited marks, walk stack, visit queue and result register
// ----------------------------------------------------------------------------
`default_nettype none
`include "graph_dfs_bfs_order_unit_macros.svh"

module gdbo_dpath import gdbo_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cmd_op_t          op,
  input  wire logic [VID_W-1:0] from_vertex,
  input  wire logic [VID_W-1:0] to_vertex,
  input  wire logic             cfg_write,
  input  wire logic [VID_W-1:0] cfg_data,
  output status_t               status,
  output logic                  result_strobe,
  output logic [VID_W-1:0]      visited_vertex,
  output logic                  traversal_kind,
  output logic                  end_of_run
);

  logic [MAX_V-1:0] rows [MAX_V];
  logic [MAX_V-1:0] visited;
  logic [IDX_W-1:0] stack [MAX_V];
  logic [CNT_W-1:0] depth;
  logic [IDX_W-1:0] queue [MAX_V];
  logic [CNT_W-1:0] head;
  logic [CNT_W-1:0] tail;
  logic [IDX_W-1:0] bfs_u;
  logic [VID_W-1:0] vertex_count;

  logic [VID_W-1:0] n_eff;
  logic [MAX_V-1:0] mask;
  logic [CNT_W-1:0] depth_m1;
  logic [IDX_W-1:0] src;
  logic [MAX_V-1:0] cand;
  logic [IDX_W-1:0] w;
  logic [MAX_V-1:0] w_bit;
  logic             edge_ok;
  logic [VID_W-1:0] from_m1;
  logic [VID_W-1:0] to_m1;

  // clamp the vertex count to 1..MAX_V
  always_comb begin
    n_eff = vertex_count;
    if (vertex_count == '0) n_eff = VID_W'(1);
    else if (vertex_count > VID_W'(MAX_V)) n_eff = VID_W'(MAX_V);
    for (int i = 0; i < MAX_V; i++) begin
      mask[i] = (VID_W'(i) < n_eff);
    end
  end

  assign from_m1  = from_vertex - VID_W'(1);
  assign to_m1    = to_vertex - VID_W'(1);
  assign edge_ok  = (from_vertex != '0) && (from_vertex <= n_eff) &&
                    (to_vertex != '0) && (to_vertex <= n_eff);

  assign depth_m1 = depth - CNT_W'(1);
  assign src      = (op == CMD_BFS_EXPAND) ? bfs_u : stack[depth_m1[IDX_W-1:0]];
  assign cand     = rows[src] & mask & ~visited;
  assign w        = lowest_set(cand);
  assign w_bit    = MAX_V'(1) << w;

  assign status.stack_empty = (depth == '0);
  assign status.cand_none   = (cand == '0);
  assign status.queue_empty = (head == tail);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_V; i++) rows[i] <= '0;
      visited       <= '0;
      depth         <= '0;
      head          <= '0;
      tail          <= '0;
      vertex_count  <= VID_W'(MAX_V);
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      if (cfg_write) vertex_count <= cfg_data;
      case (op)
        CMD_LOAD: begin
          if (edge_ok) rows[from_m1[IDX_W-1:0]][to_m1[IDX_W-1:0]] <= 1'b1;
        end
        CMD_DFS_ROOT: begin
          visited       <= MAX_V'(1);
          depth         <= CNT_W'(1);
          result_strobe <= 1'b1;
        end
        CMD_DFS_STEP: begin
          if (status.cand_none) begin
            depth <= depth_m1;
          end else begin
            visited       <= visited | w_bit;
            result_strobe <= 1'b1;
            if (depth < CNT_W'(MAX_V)) depth <= depth + CNT_W'(1);
          end
        end
        CMD_BFS_ROOT: begin
          visited <= MAX_V'(1);
          head    <= '0;
          tail    <= CNT_W'(1);
        end
        CMD_BFS_POP: begin
          head <= head + CNT_W'(1);
        end
        CMD_BFS_EXPAND: begin
          if (!status.cand_none) begin
            visited <= visited | w_bit;
            if (tail < CNT_W'(MAX_V)) tail <= tail + CNT_W'(1);
          end else begin
            result_strobe <= 1'b1;
          end
        end
        CMD_CLEAR: begin
          for (int i = 0; i < MAX_V; i++) rows[i] <= '0;
          visited <= '0;
          depth   <= '0;
          head    <= '0;
          tail    <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // stack, queue and result payload
  always_ff @(posedge clk) begin
    case (op)
      CMD_DFS_ROOT: begin
        stack[0]       <= '0;
        visited_vertex <= VID_W'(1);
        traversal_kind <= 1'b0;
        end_of_run     <= 1'b0;
      end
      CMD_DFS_STEP: begin
        if (!status.cand_none) begin
          if (depth < CNT_W'(MAX_V)) stack[depth[IDX_W-1:0]] <= w;
          visited_vertex <= VID_W'(w) + VID_W'(1);
          traversal_kind <= 1'b0;
          end_of_run     <= 1'b0;
        end
      end
      CMD_BFS_ROOT: begin
        queue[0] <= '0;
      end
      CMD_BFS_POP: begin
        bfs_u <= queue[head[IDX_W-1:0]];
      end
      CMD_BFS_EXPAND: begin
        if (!status.cand_none) begin
          if (tail < CNT_W'(MAX_V)) queue[tail[IDX_W-1:0]] <= w;
        end else begin
          visited_vertex <= VID_W'(bfs_u) + VID_W'(1);
          traversal_kind <= 1'b1;
          end_of_run     <= status.queue_empty;
        end
      end
      default: begin
      end
    endcase
  end

  `GDBO_ASSERT_NEXT(a_root_emit, clk, rst, op == CMD_DFS_ROOT, result_strobe && (visited_vertex == VID_W'(1)) && !traversal_kind, "dfs root not emitted as vertex 1")
  `GDBO_ASSERT_NEXT(a_dfs_push_emit, clk, rst, (op == CMD_DFS_STEP) && !status.cand_none, result_strobe && !traversal_kind, "dfs push without a result")
  `GDBO_ASSERT_SAME(a_eor_kind, clk, rst, result_strobe && end_of_run, traversal_kind, "end of run on a depth-first result")
  `GDBO_ASSERT_NEXT(a_clear_done, clk, rst, op == CMD_CLEAR, (visited == '0) && (depth == '0) && (head == '0) && (tail == '0), "walk state not cleared")

endmodule

`default_nettype wire
